// File: src/spwm_pkg.sv
// Shared constants, types and register codes for the three-phase sine PWM generator.
// No dependencies; the other source files refer to this package by scoped names, the bench imports it.
package spwm_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned FRAC_BITS   = 16;

  // field and state widths
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned TVAL_W   = 8;
  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned AMP_W    = 24;
  localparam int unsigned PRE_W    = 23;
  localparam int unsigned DLY_W    = 27;
  localparam int unsigned PRE_OUT_W = 7;
  localparam int unsigned DLY_OUT_W = 11;

  // configuration register widths
  localparam int unsigned ISTEP_W  = 7;
  localparam int unsigned ASTEP_W  = 16;
  localparam int unsigned PSTEP_W  = 16;
  localparam int unsigned PFLOOR_W = 7;
  localparam int unsigned DSTEP_W  = 20;
  localparam int unsigned DFLOOR_W = 11;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_STEP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALER_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALER_FLOOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_FLOOR     = 3'd5;

  // request kinds
  localparam logic KIND_TABLE_WR = 1'b0;
  localparam logic KIND_TICK     = 1'b1;

  // configuration reset values
  localparam logic [ISTEP_W-1:0]  ISTEP_RST  = 7'd1;
  localparam logic [ASTEP_W-1:0]  ASTEP_RST  = 16'd1638;
  localparam logic [PSTEP_W-1:0]  PSTEP_RST  = 16'd655;
  localparam logic [PFLOOR_W-1:0] PFLOOR_RST = 7'd40;
  localparam logic [DSTEP_W-1:0]  DSTEP_RST  = 20'd6554;
  localparam logic [DFLOOR_W-1:0] DFLOOR_RST = 11'd255;

  // state reset values
  localparam logic [IDX_W-1:0] IDX_A_RST = 8'd0;
  localparam logic [IDX_W-1:0] IDX_B_RST = 8'd85;
  localparam logic [IDX_W-1:0] IDX_C_RST = 8'd43;
  localparam logic POL_A_RST = 1'b1;
  localparam logic POL_B_RST = 1'b1;
  localparam logic POL_C_RST = 1'b0;
  localparam logic [AMP_W-1:0] AMP_RST = '0;
  localparam logic [PRE_W-1:0] PRE_RST = PRE_W'(80 << FRAC_BITS);
  localparam logic [DLY_W-1:0] DLY_RST = DLY_W'(2000 << FRAC_BITS);

  // arithmetic constants
  localparam logic [AMP_W-1:0]  AMP_LIMIT = AMP_W'(254 << FRAC_BITS);
  localparam logic [AMP_W-1:0]  AMP_MAX   = AMP_W'(255 << FRAC_BITS);
  localparam logic [IDX_W-1:0]  OFFSET_B  = 8'd85;
  localparam logic [IDX_W-1:0]  OFFSET_C  = 8'd43;
  localparam logic [DUTY_W-1:0] DUTY_MID  = 8'd127;

  typedef struct packed {
    logic [ISTEP_W-1:0]  index_step;
    logic [ASTEP_W-1:0]  amplitude_step;
    logic [PSTEP_W-1:0]  prescaler_step;
    logic [PFLOOR_W-1:0] prescaler_floor;
    logic [DSTEP_W-1:0]  delay_step;
    logic [DFLOOR_W-1:0] delay_floor;
  } cfg_t;

  // per-tick values that travel alongside the table read
  typedef struct packed {
    logic                 pol_a;
    logic                 pol_b;
    logic                 pol_c;
    logic [7:0]           amp_int;
    logic [PRE_OUT_W-1:0] prescaler;
    logic [DLY_OUT_W-1:0] delay;
  } tick_t;

endpackage

// File: src/spwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies beyond spwm_pkg for default sizes.
module spwm_ram #(
  parameter int unsigned Width = spwm_pkg::TVAL_W,
  parameter int unsigned Depth = spwm_pkg::TABLE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/spwm_state.sv
// Generator state: phase indices, polarities and the three Q.16 ramps.
// Depends on spwm_pkg. Gives the table read addresses and per-tick values.
module spwm_state (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tick_i,
  input  spwm_pkg::cfg_t                  cfg_i,
  output logic [spwm_pkg::IDX_W-1:0]      rd_addr_a_o,
  output logic [spwm_pkg::IDX_W-1:0]      rd_addr_b_o,
  output logic [spwm_pkg::IDX_W-1:0]      rd_addr_c_o,
  output spwm_pkg::tick_t                 info_o
);

  logic [spwm_pkg::IDX_W-1:0] idx_a_q, idx_b_q, idx_c_q;
  logic [spwm_pkg::IDX_W-1:0] idx_a_d, idx_b_d, idx_c_d;
  logic [spwm_pkg::IDX_W-1:0] wrap_a, wrap_b, wrap_c;
  logic pol_a_q, pol_b_q, pol_c_q;
  logic pol_a_d, pol_b_d, pol_c_d;
  logic [spwm_pkg::AMP_W-1:0] amp_q, amp_d;
  logic [spwm_pkg::PRE_W-1:0] pre_q, pre_d, pre_floor;
  logic [spwm_pkg::DLY_W-1:0] dly_q, dly_d, dly_floor;
  logic [spwm_pkg::AMP_W:0]   amp_sum;
  logic [spwm_pkg::PRE_W:0]   pre_diff;
  logic [spwm_pkg::DLY_W:0]   dly_diff;

  // ramps: a borrow or a result under the floor lands on the floor; amplitude above its limit goes to max
  always_comb begin
    pre_floor = {cfg_i.prescaler_floor, spwm_pkg::FRAC_BITS'(0)};
    pre_diff  = {1'b0, pre_q} - (spwm_pkg::PRE_W + 1)'(cfg_i.prescaler_step);
    pre_d     = (pre_diff[spwm_pkg::PRE_W] || (pre_diff[spwm_pkg::PRE_W-1:0] < pre_floor))
                ? pre_floor : pre_diff[spwm_pkg::PRE_W-1:0];

    dly_floor = {cfg_i.delay_floor, spwm_pkg::FRAC_BITS'(0)};
    dly_diff  = {1'b0, dly_q} - (spwm_pkg::DLY_W + 1)'(cfg_i.delay_step);
    dly_d     = (dly_diff[spwm_pkg::DLY_W] || (dly_diff[spwm_pkg::DLY_W-1:0] < dly_floor))
                ? dly_floor : dly_diff[spwm_pkg::DLY_W-1:0];

    amp_sum = {1'b0, amp_q} + (spwm_pkg::AMP_W + 1)'(cfg_i.amplitude_step);
    amp_d   = (amp_sum > {1'b0, spwm_pkg::AMP_LIMIT}) ? spwm_pkg::AMP_MAX
              : amp_sum[spwm_pkg::AMP_W-1:0];
  end

  // half-wave wraps; an A wrap resynchronises B and C
  always_comb begin
    if (idx_a_q[spwm_pkg::IDX_W-1]) begin
      wrap_a  = {1'b0, idx_a_q[spwm_pkg::IDX_W-2:0]};
      wrap_b  = wrap_a + spwm_pkg::OFFSET_B;
      wrap_c  = wrap_a + spwm_pkg::OFFSET_C;
      pol_a_d = ~pol_a_q;
      pol_b_d = ~pol_a_q;
      pol_c_d = pol_a_q;
    end else begin
      wrap_a  = idx_a_q;
      wrap_b  = {1'b0, idx_b_q[spwm_pkg::IDX_W-2:0]};
      wrap_c  = {1'b0, idx_c_q[spwm_pkg::IDX_W-2:0]};
      pol_a_d = pol_a_q;
      pol_b_d = pol_b_q ^ idx_b_q[spwm_pkg::IDX_W-1];
      pol_c_d = pol_c_q ^ idx_c_q[spwm_pkg::IDX_W-1];
    end
    idx_a_d = wrap_a + spwm_pkg::IDX_W'(cfg_i.index_step);
    idx_b_d = wrap_b + spwm_pkg::IDX_W'(cfg_i.index_step);
    idx_c_d = wrap_c + spwm_pkg::IDX_W'(cfg_i.index_step);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_a_q <= spwm_pkg::IDX_A_RST;
      idx_b_q <= spwm_pkg::IDX_B_RST;
      idx_c_q <= spwm_pkg::IDX_C_RST;
      pol_a_q <= spwm_pkg::POL_A_RST;
      pol_b_q <= spwm_pkg::POL_B_RST;
      pol_c_q <= spwm_pkg::POL_C_RST;
      amp_q   <= spwm_pkg::AMP_RST;
      pre_q   <= spwm_pkg::PRE_RST;
      dly_q   <= spwm_pkg::DLY_RST;
    end else if (tick_i) begin
      idx_a_q <= idx_a_d;
      idx_b_q <= idx_b_d;
      idx_c_q <= idx_c_d;
      pol_a_q <= pol_a_d;
      pol_b_q <= pol_b_d;
      pol_c_q <= pol_c_d;
      amp_q   <= amp_d;
      pre_q   <= pre_d;
      dly_q   <= dly_d;
    end
  end

  assign rd_addr_a_o = wrap_a;
  assign rd_addr_b_o = wrap_b;
  assign rd_addr_c_o = wrap_c;

  assign info_o.pol_a     = pol_a_d;
  assign info_o.pol_b     = pol_b_d;
  assign info_o.pol_c     = pol_c_d;
  assign info_o.amp_int   = amp_d[spwm_pkg::AMP_W-1:spwm_pkg::FRAC_BITS];
  assign info_o.prescaler = pre_d[spwm_pkg::FRAC_BITS +: spwm_pkg::PRE_OUT_W];
  assign info_o.delay     = dly_d[spwm_pkg::FRAC_BITS +: spwm_pkg::DLY_OUT_W];

endmodule

// File: src/spwm_duty.sv
// Duty stage and output register: scales the table entries by the amplitude.
// Depends on spwm_pkg. Holds the in-flight tick and the result register.
module spwm_duty (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  spwm_pkg::tick_t                  info_i,
  input  logic [spwm_pkg::TVAL_W-1:0]      tab_a_i,
  input  logic [spwm_pkg::TVAL_W-1:0]      tab_b_i,
  input  logic [spwm_pkg::TVAL_W-1:0]      tab_c_i,
  output logic                             ready_o,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic [spwm_pkg::DUTY_W-1:0]      duty_a_o,
  output logic [spwm_pkg::DUTY_W-1:0]      duty_b_o,
  output logic [spwm_pkg::DUTY_W-1:0]      duty_c_o,
  output logic [spwm_pkg::PRE_OUT_W-1:0]   prescaler_o,
  output logic [spwm_pkg::DLY_OUT_W-1:0]   delay_o
);

  function automatic logic [spwm_pkg::DUTY_W-1:0] duty_of(
    input logic [7:0]                  amp,
    input logic [spwm_pkg::TVAL_W-1:0] tab,
    input logic                        positive
  );
    logic [15:0]                 prod;
    logic [7:0]                  mag;
    logic [spwm_pkg::DUTY_W:0]   sum;
    logic [spwm_pkg::DUTY_W-1:0] res;
    prod = {8'd0, amp} * {8'd0, tab};
    mag  = prod[15:8];
    sum  = {1'b0, spwm_pkg::DUTY_MID} + {1'b0, mag};
    if (positive) begin
      res = sum[spwm_pkg::DUTY_W] ? '1 : sum[spwm_pkg::DUTY_W-1:0];
    end else begin
      res = (mag > spwm_pkg::DUTY_MID) ? '0 : spwm_pkg::DUTY_MID - mag;
    end
    return res;
  endfunction

  logic            s1_valid_q, s1_valid_d;
  spwm_pkg::tick_t s1_info_q;
  logic            out_valid_q, out_valid_d;
  logic            out_free, move;

  logic [spwm_pkg::DUTY_W-1:0]    duty_a_q, duty_b_q, duty_c_q;
  logic [spwm_pkg::PRE_OUT_W-1:0] pre_q;
  logic [spwm_pkg::DLY_OUT_W-1:0] dly_q;

  assign out_free    = !out_valid_q || ready_i;
  assign move        = s1_valid_q && out_free;
  assign ready_o     = !s1_valid_q || out_free;
  assign s1_valid_d  = load_i || (s1_valid_q && !move);
  assign out_valid_d = move || (out_valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // table data sits in the RAM read registers while the tick waits here
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_info_q <= info_i;
    end
    if (move) begin
      duty_a_q <= duty_of(s1_info_q.amp_int, tab_a_i, s1_info_q.pol_a);
      duty_b_q <= duty_of(s1_info_q.amp_int, tab_b_i, s1_info_q.pol_b);
      duty_c_q <= duty_of(s1_info_q.amp_int, tab_c_i, s1_info_q.pol_c);
      pre_q    <= s1_info_q.prescaler;
      dly_q    <= s1_info_q.delay;
    end
  end

  assign valid_o     = out_valid_q;
  assign duty_a_o    = duty_a_q;
  assign duty_b_o    = duty_b_q;
  assign duty_c_o    = duty_c_q;
  assign prescaler_o = pre_q;
  assign delay_o     = dly_q;

endmodule

// File: src/three_phase_sine_pwm_generator_unit.sv
// Top level of the soft-start three-phase sine PWM generator.
// Depends on spwm_pkg, spwm_ram, spwm_state and spwm_duty.
//
//  port group  | dir | fields (low bit first)                         | role
//  s_axis_*    | in  | tuser: kind; tdata: table_index, table_value    | table write or tick
//  m_axis_*    | out | tdata: duty_a, duty_b, duty_c, prescaler, delay | one result per tick
//  cfg_*_i     | in  | index, data                                     | register write
//
// One request can be taken every cycle while s_axis_tready is high. A tick's result passes
// through the registered table read and then the duty multiply into the output register.
// Three copies of the table, each with its own read port, serve the three phases.
// Table writes finish in the accepting cycle and give no result.
// Reset is asynchronous and clears all state but the table (undefined) and the data registers.
// With the result stalled, one more tick is held and then s_axis_tready drops.
module three_phase_sine_pwm_generator_unit #(
  parameter int unsigned TableDepth = spwm_pkg::TABLE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [15:0]                       s_axis_tdata,  // table_index, table_value
  input  logic                              s_axis_tuser,  // kind
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [47:0]                       m_axis_tdata,  // duty_a, duty_b, duty_c,
                                                           // prescaler_value, delay_value
  input  logic                              cfg_we_i,
  input  logic [spwm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [spwm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned TblAw = $clog2(TableDepth);

  spwm_pkg::cfg_t cfg_q;
  logic accept, tick, tbl_wr;
  logic [spwm_pkg::IDX_W-1:0]     rd_addr_a, rd_addr_b, rd_addr_c;
  logic [spwm_pkg::TVAL_W-1:0]    tab_a, tab_b, tab_c;
  spwm_pkg::tick_t                info;
  logic [spwm_pkg::DUTY_W-1:0]    duty_a, duty_b, duty_c;
  logic [spwm_pkg::PRE_OUT_W-1:0] prescaler;
  logic [spwm_pkg::DLY_OUT_W-1:0] delay;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.index_step      <= spwm_pkg::ISTEP_RST;
      cfg_q.amplitude_step  <= spwm_pkg::ASTEP_RST;
      cfg_q.prescaler_step  <= spwm_pkg::PSTEP_RST;
      cfg_q.prescaler_floor <= spwm_pkg::PFLOOR_RST;
      cfg_q.delay_step      <= spwm_pkg::DSTEP_RST;
      cfg_q.delay_floor     <= spwm_pkg::DFLOOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spwm_pkg::REG_INDEX_STEP: begin
          cfg_q.index_step <= cfg_data_i[spwm_pkg::ISTEP_W-1:0];
        end
        spwm_pkg::REG_AMPLITUDE_STEP: begin
          cfg_q.amplitude_step <= cfg_data_i[spwm_pkg::ASTEP_W-1:0];
        end
        spwm_pkg::REG_PRESCALER_STEP: begin
          cfg_q.prescaler_step <= cfg_data_i[spwm_pkg::PSTEP_W-1:0];
        end
        spwm_pkg::REG_PRESCALER_FLOOR: begin
          cfg_q.prescaler_floor <= cfg_data_i[spwm_pkg::PFLOOR_W-1:0];
        end
        spwm_pkg::REG_DELAY_STEP: begin
          cfg_q.delay_step <= cfg_data_i[spwm_pkg::DSTEP_W-1:0];
        end
        spwm_pkg::REG_DELAY_FLOOR: begin
          cfg_q.delay_floor <= cfg_data_i[spwm_pkg::DFLOOR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign tick   = accept && (s_axis_tuser == spwm_pkg::KIND_TICK);
  assign tbl_wr = accept && (s_axis_tuser == spwm_pkg::KIND_TABLE_WR);

  spwm_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .cfg_i       (cfg_q),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .rd_addr_c_o (rd_addr_c),
    .info_o      (info)
  );

  spwm_ram #(.Width(spwm_pkg::TVAL_W), .Depth(TableDepth)) u_tbl_a (
    .clk_i   (clk_i),
    .we_i    (tbl_wr),
    .waddr_i (s_axis_tdata[TblAw-1:0]),
    .wdata_i (s_axis_tdata[15:8]),
    .re_i    (tick),
    .raddr_i (rd_addr_a[TblAw-1:0]),
    .rdata_o (tab_a)
  );

  spwm_ram #(.Width(spwm_pkg::TVAL_W), .Depth(TableDepth)) u_tbl_b (
    .clk_i   (clk_i),
    .we_i    (tbl_wr),
    .waddr_i (s_axis_tdata[TblAw-1:0]),
    .wdata_i (s_axis_tdata[15:8]),
    .re_i    (tick),
    .raddr_i (rd_addr_b[TblAw-1:0]),
    .rdata_o (tab_b)
  );

  spwm_ram #(.Width(spwm_pkg::TVAL_W), .Depth(TableDepth)) u_tbl_c (
    .clk_i   (clk_i),
    .we_i    (tbl_wr),
    .waddr_i (s_axis_tdata[TblAw-1:0]),
    .wdata_i (s_axis_tdata[15:8]),
    .re_i    (tick),
    .raddr_i (rd_addr_c[TblAw-1:0]),
    .rdata_o (tab_c)
  );

  spwm_duty u_duty (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (tick),
    .info_i      (info),
    .tab_a_i     (tab_a),
    .tab_b_i     (tab_b),
    .tab_c_i     (tab_c),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .duty_a_o    (duty_a),
    .duty_b_o    (duty_b),
    .duty_c_o    (duty_c),
    .prescaler_o (prescaler),
    .delay_o     (delay)
  );

  assign m_axis_tdata = {6'd0, delay, prescaler, duty_c, duty_b, duty_a};

endmodule

// File: src/spwm_checker.sv
// Port-level checks for the sine PWM generator, bound to the top level.
// Depends on spwm_pkg and three_phase_sine_pwm_generator_unit.
module spwm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // an accepted tick request always finds a result on offer after the table read and output registers
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == spwm_pkg::KIND_TICK)
    |-> ##2 m_axis_tvalid)
    else $error("tick request produced no result");

  // a result appearing on an empty output comes from a tick that went straight through the stage and output registers
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == spwm_pkg::KIND_TICK), 2))
    else $error("result without a tick request");

endmodule

bind three_phase_sine_pwm_generator_unit spwm_checker u_spwm_checker (.*);

// File: test/three_phase_sine_pwm_generator_unit_tb.sv
// Self-checking bench for the three-phase sine PWM generator: loads the table, runs ticks
// under many register settings and compares every result with an in-bench predictor.
// Depends on spwm_pkg and three_phase_sine_pwm_generator_unit.
module three_phase_sine_pwm_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spwm_pkg::*;

  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned PHASES    = 6;
  localparam int unsigned PHASE_LEN = 72;

  // one result word, lowest field last in the declaration
  typedef struct packed {
    logic [DLY_OUT_W-1:0] delay;
    logic [PRE_OUT_W-1:0] prescaler;
    logic [DUTY_W-1:0]    duty_c;
    logic [DUTY_W-1:0]    duty_b;
    logic [DUTY_W-1:0]    duty_a;
  } pwm_word_t;

  localparam int unsigned WORD_W = $bits(pwm_word_t);

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;   // table_index, table_value
  logic                  s_axis_tuser = 1'b0; // kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [47:0]           m_axis_tdata;        // duty_a, duty_b, duty_c, prescaler, delay
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  three_phase_sine_pwm_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [TVAL_W-1:0] sine_copy [TABLE_DEPTH];
  logic [IDX_W-1:0]  pos_a = IDX_A_RST, pos_b = IDX_B_RST, pos_c = IDX_C_RST;
  logic              sign_a = POL_A_RST, sign_b = POL_B_RST, sign_c = POL_C_RST;
  logic [AMP_W-1:0]  amp_q = AMP_RST;
  logic [PRE_W-1:0]  pre_q = PRE_RST;
  logic [DLY_W-1:0]  dly_q = DLY_RST;
  cfg_t shadow_cfg = '{index_step: ISTEP_RST, amplitude_step: ASTEP_RST,
                       prescaler_step: PSTEP_RST, prescaler_floor: PFLOOR_RST,
                       delay_step: DSTEP_RST, delay_floor: DFLOOR_RST};

  pwm_word_t   pending_duties [$];
  int unsigned mismatch_count = 0;

  // sender and receiver pacing
  int unsigned burst_left = 4;
  bit          no_gaps = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  logic [31:0] rx_cycle = '0;

  function automatic logic [31:0] ramp_toward_floor(logic [31:0] acc, logic [31:0] step,
                                                    logic [31:0] floor_units);
    logic [31:0] floor_q;
    floor_q = floor_units << FRAC_BITS;
    if (acc < step || acc - step < floor_q) return floor_q;
    return acc - step;
  endfunction

  function automatic logic [DUTY_W-1:0] duty_for(logic [7:0] amp_int, logic [7:0] entry,
                                                 logic positive);
    logic [15:0] mag;
    logic [15:0] sum;
    mag = (16'(amp_int) * 16'(entry)) >> 8;
    if (positive) begin
      sum = mag + 16'(DUTY_MID);
      return (sum > 16'd255) ? 8'd255 : sum[7:0];
    end
    return (mag > 16'(DUTY_MID)) ? 8'd0 : 8'(16'(DUTY_MID) - mag);
  endfunction

  function automatic pwm_word_t advance_waveform();
    logic [31:0] amp_next;
    logic [7:0]  amp_int;
    pwm_word_t   w;
    pre_q = PRE_W'(ramp_toward_floor(32'(pre_q), 32'(shadow_cfg.prescaler_step),
                                     32'(shadow_cfg.prescaler_floor)));
    dly_q = DLY_W'(ramp_toward_floor(32'(dly_q), 32'(shadow_cfg.delay_step),
                                     32'(shadow_cfg.delay_floor)));
    amp_next = 32'(amp_q) + 32'(shadow_cfg.amplitude_step);
    if (amp_next > 32'(AMP_LIMIT)) amp_next = 32'(AMP_MAX);
    amp_q = AMP_W'(amp_next);

    // phase A leaving its half wave realigns B and C and skips their own wraps
    if (pos_a[7]) begin
      pos_a[7] = 1'b0;
      if (sign_a) begin
        sign_a = 1'b0; sign_b = 1'b0; sign_c = 1'b1;
      end else begin
        sign_a = 1'b1; sign_b = 1'b1; sign_c = 1'b0;
      end
      pos_b = pos_a + OFFSET_B;
      pos_c = pos_a + OFFSET_C;
    end else begin
      if (pos_b[7]) begin
        pos_b[7] = 1'b0;
        sign_b = ~sign_b;
      end
      if (pos_c[7]) begin
        pos_c[7] = 1'b0;
        sign_c = ~sign_c;
      end
    end

    amp_int     = amp_q[FRAC_BITS +: 8];
    w.duty_a    = duty_for(amp_int, sine_copy[pos_a], sign_a);
    w.duty_b    = duty_for(amp_int, sine_copy[pos_b], sign_b);
    w.duty_c    = duty_for(amp_int, sine_copy[pos_c], sign_c);
    w.prescaler = pre_q[FRAC_BITS +: PRE_OUT_W];
    w.delay     = dly_q[FRAC_BITS +: DLY_OUT_W];

    pos_a = pos_a + IDX_W'(shadow_cfg.index_step);
    pos_b = pos_b + IDX_W'(shadow_cfg.index_step);
    pos_c = pos_c + IDX_W'(shadow_cfg.index_step);
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] value,
                                                      int unsigned width);
    logic [CFG_DATA_W-1:0] mask;
    mask = (CFG_DATA_W'(1) << width) - 1'b1;
    if (width >= CFG_DATA_W) mask = '1;
    return (CFG_DATA_W'($urandom) & ~mask) | (value & mask);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_extreme(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 5))
      0:       return CFG_DATA_W'(lo);
      1:       return CFG_DATA_W'(hi);
      default: return CFG_DATA_W'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endtask

  // register write, only while no tick is in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      REG_INDEX_STEP:      shadow_cfg.index_step      = data[ISTEP_W-1:0];
      REG_AMPLITUDE_STEP:  shadow_cfg.amplitude_step  = data[ASTEP_W-1:0];
      REG_PRESCALER_STEP:  shadow_cfg.prescaler_step  = data[PSTEP_W-1:0];
      REG_PRESCALER_FLOOR: shadow_cfg.prescaler_floor = data[PFLOOR_W-1:0];
      REG_DELAY_STEP:      shadow_cfg.delay_step      = data[DSTEP_W-1:0];
      REG_DELAY_FLOOR:     shadow_cfg.delay_floor     = data[DFLOOR_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_request(logic kind, logic [IDX_W-1:0] tidx, logic [TVAL_W-1:0] tval);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {tval, tidx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (kind == KIND_TICK) pending_duties.push_back(advance_waveform());
    else sine_copy[tidx] = tval;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!no_gaps) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_tick();
    send_request(KIND_TICK, IDX_W'($urandom), TVAL_W'($urandom));
  endtask

  // stop sending, wait for every outstanding tick, then leave a margin
  task automatic settle_outputs();
    s_axis_tvalid <= 1'b0;
    while (pending_duties.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_table_load();
    logic [TVAL_W-1:0] v;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      case ($urandom_range(0, 7))
        0, 1:    v = 8'd255;
        2:       v = 8'd0;
        default: v = TVAL_W'($urandom);
      endcase
      send_request(KIND_TABLE_WR, IDX_W'(i), v);
    end
    settle_outputs();
  endtask

  task automatic test_reset_defaults();
    repeat (8) send_tick();
    settle_outputs();
  endtask

  task automatic test_register_extremes();
    logic [IDX_W-1:0] target;
    // all ones: widest steps, floors above the current ramp values
    for (int r = REG_INDEX_STEP; r <= REG_DELAY_FLOOR; r++)
      write_reg(CFG_IDX_W'(r), '1);
    repeat (4) send_tick();
    settle_outputs();
    write_reg(REG_PRESCALER_FLOOR, '0);
    write_reg(REG_DELAY_FLOOR, '0);
    repeat (4) send_tick();
    settle_outputs();
    // frozen indices; writes past the register list must change nothing
    write_reg(REG_INDEX_STEP, '0);
    write_reg(CFG_IDX_W'(6), '1);
    write_reg(CFG_IDX_W'(7), '0);
    repeat (3) send_tick();
    // overwrite the entry phase A reads next and tick straight after it
    no_gaps = 1'b1;
    target = {1'b0, pos_a[6:0]};
    send_request(KIND_TABLE_WR, target, ~sine_copy[target]);
    send_tick();
    no_gaps = 1'b0;
    settle_outputs();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_INDEX_STEP,      with_junk(pick_extreme(0, 127), ISTEP_W));
      write_reg(REG_AMPLITUDE_STEP,  with_junk(pick_extreme(0, 65535), ASTEP_W));
      write_reg(REG_PRESCALER_STEP,  with_junk(pick_extreme(0, 65535), PSTEP_W));
      write_reg(REG_PRESCALER_FLOOR, with_junk(pick_extreme(0, 127), PFLOOR_W));
      write_reg(REG_DELAY_STEP,      with_junk(pick_extreme(0, 20'hFFFFF), DSTEP_W));
      write_reg(REG_DELAY_FLOOR,     with_junk(pick_extreme(0, 2047), DFLOOR_W));
      if ($urandom_range(0, 1)) write_reg(CFG_IDX_W'($urandom_range(6, 7)), CFG_DATA_W'($urandom));
      no_gaps = (p == 3);
      for (int i = 0; i < PHASE_LEN; i++) begin
        if ($urandom_range(0, 4) == 0)
          send_request(KIND_TABLE_WR, IDX_W'($urandom),
                       $urandom_range(0, 3) == 0 ? 8'd255 : TVAL_W'($urandom));
        else
          send_tick();
      end
      no_gaps = 1'b0;
      settle_outputs();
    end
  endtask

  task automatic test_backpressure();
    no_gaps = 1'b1;
    hold_reqs++;
    repeat (40) send_tick();
    no_gaps = 1'b0;
    settle_outputs();
  endtask

  // receiver: own stall pattern, plus long hold-offs on request
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_reqs != hold_done) begin
      hold_done     <= hold_done + 1;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_cycle[7:6])
        2'd0:    m_axis_tready <= 1'b1;
        2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
        2'd2:    m_axis_tready <= (rx_cycle[1:0] == 2'd0);
        default: m_axis_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    pwm_word_t got;
    pwm_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pwm_word_t'(m_axis_tdata[WORD_W-1:0]);
      if (pending_duties.size() == 0) begin
        report_mismatch("result without a tick request", 0, 32'(got));
      end else begin
        want = pending_duties.pop_front();
        if (got.duty_a !== want.duty_a)
          report_mismatch("duty_a", 32'(want.duty_a), 32'(got.duty_a));
        if (got.duty_b !== want.duty_b)
          report_mismatch("duty_b", 32'(want.duty_b), 32'(got.duty_b));
        if (got.duty_c !== want.duty_c)
          report_mismatch("duty_c", 32'(want.duty_c), 32'(got.duty_c));
        if (got.prescaler !== want.prescaler)
          report_mismatch("prescaler_value", 32'(want.prescaler), 32'(got.prescaler));
        if (got.delay !== want.delay)
          report_mismatch("delay_value", 32'(want.delay), 32'(got.delay));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_load();
    test_reset_defaults();
    test_register_extremes();
    test_random_phases();
    test_backpressure();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_duties.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
